>>> hw/rtl/mbr_pkg.sv
// Shared constants, codes and types for the multicast byte ring.
package mbr_pkg;

  // Default sizes
  localparam int RING_BYTES_DEF   = 1024;
  localparam int MAX_READERS_DEF  = 8;
  localparam int MAX_PAYLOAD_DEF  = 63;
  localparam int HEADER_BYTES_DEF = 8;

  // Action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_PUT   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  // Status codes
  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_INVALID = 3'd1;
  localparam logic [2:0] STS_FULL    = 3'd2;
  localparam logic [2:0] STS_EMPTY   = 3'd3;
  localparam logic [2:0] STS_PARTIAL = 3'd4;
  localparam logic [2:0] STS_SMALL   = 3'd5;
  localparam logic [2:0] STS_ORDER   = 3'd6;

  // Control from the sequencer to the cursor store
  typedef struct packed {
    logic scan_start;
    logic wr_en;
  } cur_ctl_t;

endpackage

>>> hw/rtl/mbr_ring.sv
// Byte ring store: one write port, one registered read port.
module mbr_ring #(
  parameter int RING_BYTES = mbr_pkg::RING_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(RING_BYTES)-1:0] wr_addr,
  input  logic [7:0]                    wr_data,
  input  logic [$clog2(RING_BYTES)-1:0] rd_addr,
  output logic [7:0]                    rd_data
);

  logic [7:0] mem [RING_BYTES];

  // Write one byte; the read byte is registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/mbr_cursors.sv
// Reader cursor store with a sequential scan for the farthest distance.
module mbr_cursors #(
  parameter int MAX_READERS = mbr_pkg::MAX_READERS_DEF,
  parameter int IW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1,
  parameter int CW = $clog2(MAX_READERS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  mbr_pkg::cur_ctl_t ctl,
  input  logic [IW-1:0]     slot,
  input  logic [31:0]       wr_data,
  input  logic [CW-1:0]     nr,
  input  logic [31:0]       wr_head,
  output logic [31:0]       rd_data,
  output logic              scan_done,
  output logic [31:0]       worst
);
  import mbr_pkg::*;

  logic [31:0]          mem [MAX_READERS];
  logic [MAX_READERS-1:0] vld;
  logic [31:0]          rd_raw;
  logic                 rd_vld;
  logic [IW-1:0]        addr;
  logic [CW-1:0]        cnt;
  logic                 scanning;
  logic                 pend;
  logic [31:0]          span;

  // Scan owns the read port while it runs
  assign addr    = scanning ? cnt[IW-1:0] : slot;
  assign rd_data = rd_vld ? rd_raw : 32'd0;
  assign span    = wr_head - rd_data;

  // Store cursors; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[slot] <= wr_data;
    end
    rd_raw <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld[slot] <= 1'b1;
      end
      rd_vld <= vld[addr];
    end
  end

  // Walk active slots, keep the largest modular distance
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning  <= 1'b0;
      pend      <= 1'b0;
      cnt       <= '0;
      scan_done <= 1'b0;
      worst     <= 32'd0;
    end else begin
      scan_done <= 1'b0;
      if (ctl.scan_start) begin
        scanning <= 1'b1;
        pend     <= 1'b0;
        cnt      <= '0;
        worst    <= 32'd0;
      end else if (scanning) begin
        pend <= (cnt < nr);
        if (cnt < nr) begin
          cnt <= cnt + 1'b1;
        end
        if (pend && (span > worst)) begin
          worst <= span;
        end
        if (!pend && (cnt == nr)) begin
          scanning  <= 1'b0;
          scan_done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/multicast_byte_ring.sv
// Top level of the multicast byte ring: command sequencer and result port.
//
// One writer opens a message (action 0), which stores a header of length and
// sequence, then sends payload bytes one per item (action 1); the message
// becomes visible to readers after its last byte. Each reader slot reads the
// next message (action 2): one header result, then one result per payload
// byte, or queries its pending bytes (action 3). Results appear for one cycle
// with result_valid and cannot be held off; last marks the final one of an
// item. A read that succeeds brings its header in over the one ring read port
// and streams its payload out one byte a cycle. Any other item that is first
// after a configuration write, and the final payload byte of a message, add a
// cursor scan. RING_BYTES must be a power of two.
module multicast_byte_ring #(
  parameter int RING_BYTES   = mbr_pkg::RING_BYTES_DEF,
  parameter int MAX_READERS  = mbr_pkg::MAX_READERS_DEF,
  parameter int MAX_PAYLOAD  = mbr_pkg::MAX_PAYLOAD_DEF,
  parameter int HEADER_BYTES = mbr_pkg::HEADER_BYTES_DEF,
  parameter int LW = $clog2(RING_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    action,
  input  logic [5:0]    payload_len,
  input  logic [7:0]    data_byte,
  input  logic [2:0]    reader_slot,
  input  logic [7:0]    dest_capacity,
  input  logic          cfg_wr,
  input  logic [3:0]    cfg_wdata,
  output logic          result_valid,
  output logic [2:0]    status,
  output logic [7:0]    data_byte_res,
  output logic [LW-1:0] length,
  output logic [LW-1:0] free_bytes,
  output logic [31:0]   sequence_no,
  output logic          last
);
  import mbr_pkg::*;

  localparam int AW = $clog2(RING_BYTES);
  localparam int IW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int CW = $clog2(MAX_READERS + 1);
  localparam int KW = $clog2(HEADER_BYTES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCHK = 4'd1;
  localparam logic [3:0] S_HWR  = 4'd2;
  localparam logic [3:0] S_RC0  = 4'd3;
  localparam logic [3:0] S_RC1  = 4'd4;
  localparam logic [3:0] S_RHDR = 4'd5;
  localparam logic [3:0] S_RCHK = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_SCAN = 4'd8;
  localparam logic [3:0] S_RPAY = 4'd9;

  logic [3:0]    state;
  logic [3:0]    ret_state;
  logic [3:0]    scan_ret;
  logic [5:0]    plen_q;
  logic [2:0]    slot_q;
  logic [7:0]    cap_q;
  logic [CW-1:0] nr;
  logic [CW-1:0] nr_next;
  logic [31:0]   wi;
  logic [31:0]   fill;
  logic [31:0]   nseq;
  logic          open_q;
  logic [5:0]    rem;
  logic          worst_ok;
  logic [KW-1:0] k;
  logic [31:0]   cur_q;
  logic [31:0]   avail_q;
  logic [63:0]   hdr;
  logic [5:0]    len_q;
  logic [31:0]   seq_q;
  logic [5:0]    pi;
  logic          ppend;
  logic [2:0]    p_status;
  logic [LW-1:0] p_len;
  logic [31:0]   p_seq;
  logic          p_last;
  logic          action_q_is_query;

  logic          accept;
  logic          put_ok;
  logic          slot_ok;
  cur_ctl_t      cctl;
  logic [31:0]   cur_rd;
  logic          scan_done;
  logic [31:0]   worst;
  logic [LW-1:0] freev;
  logic [32:0]   need;
  logic [31:0]   avail;
  logic [31:0]   hlen;
  logic [31:0]   cur_new;
  logic          ring_we;
  logic [31:0]   ring_wa_full;
  logic [31:0]   ring_ra_full;
  logic [7:0]    ring_wd;
  logic [7:0]    ring_rd;
  logic [7:0]    hbyte;
  logic [31:0]   cfg_v;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign put_ok  = open_q && (rem != 6'd0);
  assign slot_ok = (32'(reader_slot) < 32'(nr)) && (32'(reader_slot) < MAX_READERS);
  assign freev   = (worst >= 32'(RING_BYTES)) ? '0 : LW'(32'(RING_BYTES) - worst);
  assign need    = 33'(worst) + 33'(HEADER_BYTES) + 33'(plen_q);
  assign avail   = wi - cur_rd;
  assign hlen    = hdr[31:0];
  assign cur_new = cur_q + 32'(HEADER_BYTES) + hlen;

  // Clamp the reader count into its legal range
  always_comb begin
    cfg_v = 32'(cfg_wdata);
    if (cfg_v == 32'd0) begin
      cfg_v = 32'd1;
    end else if (cfg_v > MAX_READERS) begin
      cfg_v = 32'(MAX_READERS);
    end
    nr_next = CW'(cfg_v);
  end

  // Header byte k: length, then sequence, then zero padding
  always_comb begin
    case (k) inside
      KW'(0):          hbyte = {2'b00, plen_q};
      [KW'(4):KW'(7)]: hbyte = 8'(nseq >> {k[1:0], 3'b000});
      default:         hbyte = 8'd0;
    endcase
  end

  // Ring port steering
  always_comb begin
    ring_we      = 1'b0;
    ring_wa_full = fill;
    ring_wd      = data_byte;
    if (accept && (action == ACT_PUT) && put_ok) begin
      ring_we = 1'b1;
    end else if (state == S_HWR) begin
      ring_we      = 1'b1;
      ring_wa_full = wi + 32'(k);
      ring_wd      = hbyte;
    end
    if (state == S_RPAY) begin
      ring_ra_full = cur_q + 32'(HEADER_BYTES) + 32'(pi);
    end else begin
      ring_ra_full = cur_q + 32'(k);
    end
  end

  // Cursor store control
  always_comb begin
    cctl.scan_start = ((state == S_FIN) || (state == S_SCHK)) && !worst_ok;
    cctl.wr_en      = (state == S_RCHK) &&
                      !(33'(avail_q) < 33'(HEADER_BYTES) + 33'(hlen)) &&
                      !(32'(cap_q) < hlen) && !(hlen > MAX_PAYLOAD);
  end

  mbr_ring #(.RING_BYTES(RING_BYTES)) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_wa_full[AW-1:0]),
    .wr_data (ring_wd),
    .rd_addr (ring_ra_full[AW-1:0]),
    .rd_data (ring_rd)
  );

  mbr_cursors #(.MAX_READERS(MAX_READERS), .IW(IW), .CW(CW)) u_cursors (
    .clk       (clk),
    .rst       (rst),
    .ctl       (cctl),
    .slot      (IW'(slot_q)),
    .wr_data   (cur_new),
    .nr        (nr),
    .wr_head   (wi),
    .rd_data   (cur_rd),
    .scan_done (scan_done),
    .worst     (worst)
  );

  // Capture item fields on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      plen_q <= payload_len;
      slot_q <= reader_slot;
      cap_q  <= dest_capacity;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret_state    <= S_IDLE;
      scan_ret     <= S_FIN;
      nr           <= CW'(1);
      wi           <= 32'd0;
      fill         <= 32'd0;
      nseq         <= 32'd0;
      open_q       <= 1'b0;
      rem          <= 6'd0;
      worst_ok     <= 1'b1;
      k            <= '0;
      pi           <= 6'd0;
      ppend        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_wr) begin
        nr       <= nr_next;
        worst_ok <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            p_status  <= STS_OK;
            p_len     <= '0;
            p_seq     <= 32'd0;
            p_last    <= 1'b1;
            ret_state <= S_IDLE;
            state     <= S_FIN;
            case (action)
              ACT_START: begin
                if (open_q) begin
                  p_status <= STS_ORDER;
                end else if ((payload_len == 6'd0) || (32'(payload_len) > MAX_PAYLOAD)) begin
                  p_status <= STS_INVALID;
                end else begin
                  state <= S_SCHK;
                end
              end
              ACT_PUT: begin
                if (!put_ok) begin
                  p_status <= STS_ORDER;
                end else begin
                  fill <= fill + 32'd1;
                  rem  <= rem - 6'd1;
                  if (rem == 6'd1) begin
                    open_q   <= 1'b0;
                    wi       <= fill + 32'd1;
                    worst_ok <= 1'b0;
                  end
                end
              end
              default: begin
                if (!slot_ok) begin
                  p_status <= STS_INVALID;
                end else begin
                  state <= S_RC0;
                end
              end
            endcase
          end
        end
        // Check space against the slowest reader
        S_SCHK: begin
          if (!worst_ok) begin
            scan_ret <= S_SCHK;
            state    <= S_SCAN;
          end else if (need > 33'(RING_BYTES)) begin
            p_status <= STS_FULL;
            state    <= S_FIN;
          end else begin
            k     <= '0;
            state <= S_HWR;
          end
        end
        // Write header bytes
        S_HWR: begin
          k <= k + 1'b1;
          if (k == KW'(HEADER_BYTES - 1)) begin
            fill   <= wi + 32'(HEADER_BYTES);
            open_q <= 1'b1;
            rem    <= plen_q;
            nseq   <= nseq + 32'd1;
            p_len  <= LW'(plen_q);
            p_seq  <= nseq;
            state  <= S_FIN;
          end
        end
        S_RC0: begin
          state <= S_RC1;
        end
        // Cursor is back: answer a query, refuse an empty slot or start the header fetch
        S_RC1: begin
          cur_q   <= cur_rd;
          avail_q <= avail;
          k       <= '0;
          if (action_q_is_query) begin
            p_len <= (avail > 32'(RING_BYTES)) ? LW'(RING_BYTES) : LW'(avail);
            state <= S_FIN;
          end else if (avail < 32'(HEADER_BYTES)) begin
            p_status <= STS_EMPTY;
            state    <= S_FIN;
          end else begin
            state <= S_RHDR;
          end
        end
        // Fetch the first eight header bytes
        S_RHDR: begin
          if (k != '0) begin
            hdr <= {ring_rd, hdr[63:8]};
          end
          k <= k + 1'b1;
          if (k == KW'(8)) begin
            state <= S_RCHK;
          end
        end
        // Validate the message and advance the cursor
        S_RCHK: begin
          state <= S_FIN;
          if (33'(avail_q) < 33'(HEADER_BYTES) + 33'(hlen)) begin
            p_status <= STS_PARTIAL;
          end else if (32'(cap_q) < hlen) begin
            p_status <= STS_SMALL;
          end else if (hlen > MAX_PAYLOAD) begin
            p_status <= STS_ORDER;
          end else begin
            worst_ok <= 1'b0;
            len_q    <= 6'(hlen);
            seq_q    <= hdr[63:32];
            p_len    <= LW'(hlen);
            p_seq    <= hdr[63:32];
            p_last   <= (hlen == 32'd0);
            pi       <= 6'd0;
            ppend    <= 1'b0;
            if (hlen != 32'd0) begin
              ret_state <= S_RPAY;
            end
          end
        end
        // Present the pending result once free space is current
        S_FIN: begin
          if (!worst_ok) begin
            scan_ret <= S_FIN;
            state    <= S_SCAN;
          end else begin
            result_valid  <= 1'b1;
            status        <= p_status;
            data_byte_res <= 8'd0;
            length        <= (p_status == STS_OK) ? p_len : '0;
            free_bytes    <= freev;
            sequence_no   <= (p_status == STS_OK) ? p_seq : 32'd0;
            last          <= p_last;
            state         <= ret_state;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            worst_ok <= 1'b1;
            state    <= scan_ret;
          end
        end
        // Stream payload bytes, one fetch ahead
        S_RPAY: begin
          ppend <= (pi != len_q);
          if (pi != len_q) begin
            pi <= pi + 6'd1;
          end
          if (ppend) begin
            result_valid  <= 1'b1;
            status        <= STS_OK;
            data_byte_res <= ring_rd;
            length        <= LW'(len_q);
            free_bytes    <= freev;
            sequence_no   <= seq_q;
            last          <= (pi == len_q);
          end else if (pi == len_q) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Remember whether the item is a query
  always_ff @(posedge clk) begin
    if (accept) begin
      action_q_is_query <= (action == ACT_QUERY);
    end
  end

endmodule

>>> hw/rtl/mbr_checker.sv
// Port-level checks for the multicast byte ring, bound to the top level.
module mbr_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic [2:0] status,
  input logic       last
);
  import mbr_pkg::*;

  // A transfer makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after transfer");

  // No result in the cycle right after a transfer
  a_gap: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_valid) else $error("result too early");

  // No result follows directly on the final result of an item
  a_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !result_valid) else $error("result after last");

  // Errors are single results
  a_err: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != STS_OK)) |-> last) else $error("error not last");

  // Status code stays in range
  a_sts: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status <= STS_ORDER)) else $error("bad status code");

endmodule

bind multicast_byte_ring mbr_checker u_mbr_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .status       (status),
  .last         (last)
);

>>> dv/tb_multicast_byte_ring.sv
// Testbench for the multicast byte ring: random and directed items checked against a predictor.
`timescale 1ns / 1ps
module tb_multicast_byte_ring;
  import mbr_pkg::*;

  localparam int RING      = RING_BYTES_DEF;
  localparam int NSLOT     = MAX_READERS_DEF;
  localparam int MAXLEN    = MAX_PAYLOAD_DEF;
  localparam int HDR       = HEADER_BYTES_DEF;
  localparam int LW        = $clog2(RING + 1);
  localparam int STALL_MAX = 20000;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] plen;
    logic [7:0] dbyte;
    logic [2:0] slot;
    logic [7:0] cap;
  } ring_cmd_t;

  typedef struct packed {
    logic [2:0]    status;
    logic [7:0]    dbyte;
    logic [LW-1:0] length;
    logic [LW-1:0] free;
    logic [31:0]   seq;
    logic          last;
  } ring_res_t;

  logic          clk = 1'b0;
  logic          rst;
  logic          start;
  logic          busy;
  logic [1:0]    action;
  logic [5:0]    payload_len;
  logic [7:0]    data_byte;
  logic [2:0]    reader_slot;
  logic [7:0]    dest_capacity;
  logic          cfg_wr;
  logic [3:0]    cfg_wdata;
  logic          result_valid;
  logic [2:0]    status;
  logic [7:0]    data_byte_res;
  logic [LW-1:0] length;
  logic [LW-1:0] free_bytes;
  logic [31:0]   sequence_no;
  logic          last;

  multicast_byte_ring u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .payload_len(payload_len), .data_byte(data_byte),
    .reader_slot(reader_slot), .dest_capacity(dest_capacity),
    .cfg_wr(cfg_wr), .cfg_wdata(cfg_wdata),
    .result_valid(result_valid), .status(status), .data_byte_res(data_byte_res),
    .length(length), .free_bytes(free_bytes), .sequence_no(sequence_no), .last(last)
  );

  always #6 clk = ~clk;

  // Predicted ring state
  logic [7:0]  ring_mem [RING];
  logic [31:0] cursor [NSLOT];
  logic [31:0] wr_idx, fill_idx, seq_next;
  logic        msg_open;
  int unsigned bytes_left;
  int unsigned active_readers;

  ring_cmd_t cmd_q[$];
  ring_res_t want_q[$];
  ring_cmd_t in_flight;
  int          idle_pct;
  int          mismatches;
  int unsigned stall_cnt;
  // generator view of the open message
  int          gen_left;

  function automatic logic [31:0] slowest_distance();
    logic [31:0] worst, d;
    worst = '0;
    for (int i = 0; i < active_readers; i++) begin
      d = wr_idx - cursor[i];
      if (d > worst) worst = d;
    end
    return worst;
  endfunction

  function automatic logic [LW-1:0] writer_space();
    logic [31:0] used;
    used = slowest_distance();
    return (used >= RING) ? '0 : LW'(RING - used);
  endfunction

  function automatic logic [31:0] ring_word(logic [31:0] idx);
    logic [31:0] v;
    v = '0;
    for (int b = 3; b >= 0; b--) v = (v << 8) | ring_mem[(idx + b) % RING];
    return v;
  endfunction

  task automatic push_result(logic [2:0] st, logic [7:0] b, logic [31:0] len,
                             logic [31:0] sq, logic lst);
    ring_res_t r;
    r.status = st;
    r.dbyte  = b;
    r.length = LW'(len);
    r.free   = writer_space();
    r.seq    = sq;
    r.last   = lst;
    want_q.push_back(r);
  endtask

  // Advance the ring state by one command and queue what it returns
  task automatic predict_ring(ring_cmd_t c);
    logic [31:0] cur, avail, len, sq;
    case (c.action)
      ACT_START: begin
        if (msg_open) push_result(STS_ORDER, 0, 0, 0, 1);
        else if (c.plen == 0 || c.plen > MAXLEN) push_result(STS_INVALID, 0, 0, 0, 1);
        else if (slowest_distance() + HDR + c.plen > RING) push_result(STS_FULL, 0, 0, 0, 1);
        else begin
          sq = seq_next;
          seq_next = sq + 1;
          for (int i = 0; i < HDR; i++)
            ring_mem[(wr_idx + i) % RING] =
              (i < 4) ? 8'((32'(c.plen)) >> (8 * i)) : (i < 8) ? 8'(sq >> (8 * (i - 4))) : 8'h00;
          fill_idx   = wr_idx + HDR;
          msg_open   = 1'b1;
          bytes_left = c.plen;
          push_result(STS_OK, 0, c.plen, sq, 1);
        end
      end
      ACT_PUT: begin
        if (!msg_open || bytes_left == 0) push_result(STS_ORDER, 0, 0, 0, 1);
        else begin
          ring_mem[fill_idx % RING] = c.dbyte;
          fill_idx++;
          bytes_left--;
          if (bytes_left == 0) begin
            msg_open = 1'b0;
            wr_idx   = fill_idx;
          end
          push_result(STS_OK, 0, 0, 0, 1);
        end
      end
      default: begin
        if (c.slot >= active_readers) push_result(STS_INVALID, 0, 0, 0, 1);
        else if (c.action == ACT_QUERY) begin
          avail = wr_idx - cursor[c.slot];
          if (avail > RING) avail = RING;
          push_result(STS_OK, 0, avail, 0, 1);
        end else begin
          cur   = cursor[c.slot];
          avail = wr_idx - cur;
          len   = ring_word(cur);
          sq    = ring_word(cur + 4);
          if (avail < HDR) push_result(STS_EMPTY, 0, 0, 0, 1);
          else if (64'(avail) < 64'(HDR) + 64'(len)) push_result(STS_PARTIAL, 0, 0, 0, 1);
          else if (32'(c.cap) < len) push_result(STS_SMALL, 0, 0, 0, 1);
          else if (len > MAXLEN) push_result(STS_ORDER, 0, 0, 0, 1);
          else begin
            cursor[c.slot] = cur + HDR + len;
            push_result(STS_OK, 0, len, sq, len == 0);
            for (int i = 0; i < len; i++)
              push_result(STS_OK, ring_mem[(cur + HDR + i) % RING], len, sq, i + 1 == len);
          end
        end
      end
    endcase
  endtask

  task automatic report(string field, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch on %s: got %0d, want %0d at %0t", field, got, exp_val, $realtime);
    mismatches++;
  endtask

  // Driver: hold start until the transfer, then fetch the next command
  always @(posedge clk) begin
    logic taken;
    ring_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) predict_ring(in_flight);
      if (!start || taken) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = cmd_q.pop_front();
          in_flight     = nxt;
          action        <= nxt.action;
          payload_len   <= nxt.plen;
          data_byte     <= nxt.dbyte;
          reader_slot   <= nxt.slot;
          dest_capacity <= nxt.cap;
          start         <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    ring_res_t w;
    if (!rst && result_valid) begin
      if (want_q.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        mismatches++;
      end else begin
        w = want_q.pop_front();
        if (status !== w.status) report("status", status, w.status);
        if (data_byte_res !== w.dbyte) report("data_byte_res", data_byte_res, w.dbyte);
        if (length !== w.length) report("length", length, w.length);
        if (free_bytes !== w.free) report("free_bytes", free_bytes, w.free);
        if (sequence_no !== w.seq) report("sequence_no", sequence_no, w.seq);
        if (last !== w.last) report("last", last, w.last);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) stall_cnt <= 0;
    else if (stall_cnt >= STALL_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end else stall_cnt <= stall_cnt + 1;
  end

  task automatic add_cmd(logic [1:0] act, logic [5:0] pl, logic [7:0] db, logic [2:0] sl,
                         logic [7:0] cp);
    ring_cmd_t c;
    c.action = act;
    c.plen   = pl;
    c.dbyte  = db;
    c.slot   = sl;
    c.cap    = cp;
    cmd_q.push_back(c);
  endtask

  task automatic add_read(logic [1:0] act, int slot_hi);
    add_cmd(act, 6'($urandom), 8'($urandom), 3'($urandom_range(slot_hi)),
            ($urandom_range(9) == 0) ? 8'($urandom) : 8'hFF);
  endtask

  // Mostly well-formed messages with random content; a little noise
  task automatic gen_traffic(int n, int read_pct, int long_pct);
    int pl;
    for (int k = 0; k < n; k++) begin
      if (gen_left > 0 && $urandom_range(99) < 92) begin
        add_cmd(ACT_PUT, 6'($urandom), 8'($urandom), 3'($urandom), 8'($urandom));
        gen_left--;
      end else if ($urandom_range(99) < read_pct) begin
        add_read(($urandom_range(3) == 0) ? ACT_QUERY : ACT_READ, 7);
      end else if ($urandom_range(19) == 0) begin
        add_cmd(ACT_PUT, 6'($urandom), 8'($urandom), 3'($urandom), 8'($urandom));
      end else begin
        pl = ($urandom_range(99) < long_pct) ? MAXLEN :
             ($urandom_range(19) == 0) ? 0 : $urandom_range(MAXLEN, 1);
        add_cmd(ACT_START, 6'(pl), 8'($urandom), 3'($urandom), 8'($urandom));
        if (gen_left == 0 && pl != 0) gen_left = pl;
      end
    end
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || start || busy || want_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_readers(logic [3:0] v);
    @(posedge clk);
    cfg_wr    <= 1'b1;
    cfg_wdata <= v;
    active_readers = (v == 0) ? 1 : (v > NSLOT) ? NSLOT : v;
    @(posedge clk);
    cfg_wr <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = '0;
    payload_len = '0;
    data_byte = '0;
    reader_slot = '0;
    dest_capacity = '0;
    cfg_wr = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < RING; i++) ring_mem[i] = '0;
    for (int i = 0; i < NSLOT; i++) cursor[i] = '0;
    wr_idx = '0;
    fill_idx = '0;
    seq_next = '0;
    msg_open = 1'b0;
    bytes_left = 0;
    active_readers = 1;
    idle_pct = 31;
    mismatches = 0;
    gen_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty read, bad slot, stray byte, length errors, small buffer
    add_cmd(ACT_READ, 0, 0, 0, 8'hFF);
    add_cmd(ACT_QUERY, 0, 0, 0, 0);
    add_cmd(ACT_QUERY, 0, 0, 3'd7, 0);
    add_cmd(ACT_READ, 0, 0, 3'd1, 8'hFF);
    add_cmd(ACT_PUT, 6'h3F, 8'h5A, 0, 0);
    add_cmd(ACT_START, 6'd0, 0, 0, 0);
    add_cmd(ACT_START, 6'd1, 0, 0, 0);
    add_cmd(ACT_START, 6'd2, 0, 0, 0);
    add_cmd(ACT_PUT, 0, 8'hFF, 3'd7, 8'hFF);
    add_cmd(ACT_READ, 0, 0, 0, 8'd0);
    add_cmd(ACT_QUERY, 0, 0, 0, 0);
    add_cmd(ACT_READ, 0, 0, 0, 8'd1);
    add_cmd(ACT_READ, 0, 0, 0, 8'hFF);
    add_cmd(ACT_START, 6'd2, 0, 0, 0);
    add_cmd(ACT_PUT, 0, 8'h00, 0, 0);
    add_cmd(ACT_PUT, 0, 8'hAA, 0, 0);
    add_cmd(ACT_PUT, 0, 8'h11, 0, 0);
    add_cmd(ACT_READ, 6'h3F, 8'hFF, 0, 8'd2);
    add_cmd(ACT_READ, 0, 0, 0, 8'hFF);
    drain();

    // Phase one: sender idles often, several readers
    write_readers(4'd15);
    gen_traffic(50, 30, 10);
    drain();

    // Phase two: sender idles most of the time, readers cut back to the minimum
    idle_pct = 78;
    write_readers(4'd0);
    gen_traffic(40, 35, 10);
    drain();

    // Phase three: back-to-back commands, lagging readers, long messages
    idle_pct = 0;
    write_readers(4'd3);
    gen_traffic(45, 10, 40);
    drain();
    write_readers(4'd8);
    gen_traffic(25, 60, 10);
    // close any message left open so the end is clean
    while (gen_left > 0) begin
      add_cmd(ACT_PUT, 0, 8'($urandom), 0, 0);
      gen_left--;
    end
    drain();
    repeat (200) @(posedge clk);

    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
